// ===== hw/rtl/cpu6502_pkg.sv =====
`default_nettype none

package cpu6502_pkg;

	// Mnemonic numbers, alphabetical order
	localparam logic [5:0] OP_ADC = 6'd0;
	localparam logic [5:0] OP_AND = 6'd1;
	localparam logic [5:0] OP_ASL = 6'd2;
	localparam logic [5:0] OP_BCC = 6'd3;
	localparam logic [5:0] OP_BCS = 6'd4;
	localparam logic [5:0] OP_BEQ = 6'd5;
	localparam logic [5:0] OP_BIT = 6'd6;
	localparam logic [5:0] OP_BMI = 6'd7;
	localparam logic [5:0] OP_BNE = 6'd8;
	localparam logic [5:0] OP_BPL = 6'd9;
	localparam logic [5:0] OP_BRK = 6'd10;
	localparam logic [5:0] OP_BVC = 6'd11;
	localparam logic [5:0] OP_BVS = 6'd12;
	localparam logic [5:0] OP_CLC = 6'd13;
	localparam logic [5:0] OP_CLD = 6'd14;
	localparam logic [5:0] OP_CLI = 6'd15;
	localparam logic [5:0] OP_CLV = 6'd16;
	localparam logic [5:0] OP_CMP = 6'd17;
	localparam logic [5:0] OP_CPX = 6'd18;
	localparam logic [5:0] OP_CPY = 6'd19;
	localparam logic [5:0] OP_DEC = 6'd20;
	localparam logic [5:0] OP_DEX = 6'd21;
	localparam logic [5:0] OP_DEY = 6'd22;
	localparam logic [5:0] OP_EOR = 6'd23;
	localparam logic [5:0] OP_INC = 6'd24;
	localparam logic [5:0] OP_INX = 6'd25;
	localparam logic [5:0] OP_INY = 6'd26;
	localparam logic [5:0] OP_JMP = 6'd27;
	localparam logic [5:0] OP_JSR = 6'd28;
	localparam logic [5:0] OP_LDA = 6'd29;
	localparam logic [5:0] OP_LDX = 6'd30;
	localparam logic [5:0] OP_LDY = 6'd31;
	localparam logic [5:0] OP_LSR = 6'd32;
	localparam logic [5:0] OP_NOP = 6'd33;
	localparam logic [5:0] OP_ORA = 6'd34;
	localparam logic [5:0] OP_PHA = 6'd35;
	localparam logic [5:0] OP_PHP = 6'd36;
	localparam logic [5:0] OP_PLA = 6'd37;
	localparam logic [5:0] OP_PLP = 6'd38;
	localparam logic [5:0] OP_ROL = 6'd39;
	localparam logic [5:0] OP_ROR = 6'd40;
	localparam logic [5:0] OP_RTI = 6'd41;
	localparam logic [5:0] OP_RTS = 6'd42;
	localparam logic [5:0] OP_SBC = 6'd43;
	localparam logic [5:0] OP_SEC = 6'd44;
	localparam logic [5:0] OP_SED = 6'd45;
	localparam logic [5:0] OP_SEI = 6'd46;
	localparam logic [5:0] OP_STA = 6'd47;
	localparam logic [5:0] OP_STX = 6'd48;
	localparam logic [5:0] OP_STY = 6'd49;
	localparam logic [5:0] OP_TAX = 6'd50;
	localparam logic [5:0] OP_TAY = 6'd51;
	localparam logic [5:0] OP_TSX = 6'd52;
	localparam logic [5:0] OP_TXA = 6'd53;
	localparam logic [5:0] OP_TXS = 6'd54;
	localparam logic [5:0] OP_TYA = 6'd55;

	localparam logic [7:0] SP_RESET = 8'hFF;

	typedef struct packed {
		logic [5:0] kind;
		logic [7:0] operand;
		logic       on_accumulator;
	} instr_item_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       write_back;
		logic       branch_taken;
		logic [7:0] acc_value;
		logic [7:0] index_x_value;
		logic [7:0] index_y_value;
		logic [7:0] stack_value;
		logic [7:0] status_value;
	} retire_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpu6502_if.sv =====
`default_nettype none

// Instruction channel
interface cpu6502_instr_if;
	import cpu6502_pkg::*;

	logic        valid;
	logic        ready;
	instr_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Retire channel
interface cpu6502_retire_if;
	import cpu6502_pkg::*;

	logic         valid;
	logic         ready;
	retire_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpu6502_execute_unit.sv =====
`default_nettype none

// Channel   Dir  Payload
// instr     in   kind, operand, on_accumulator
// retire    out  result_byte, write_back, branch_taken, A, X, Y, S, P
//
// One item per cycle unless retire stalls: an item is held in the input register,
// the 8-bit ALU and flag logic runs, and the result register and A/X/Y/S/P load
// at the same edge. Retire valid follows acceptance via both registers in turn.
// Reset clears A, X, Y, P, sets S to 0xFF and empties both registers.
// A stalled retire output holds the input register; instr.ready drops only
// when both stages are full and retire is not taken.
module cpu6502_execute_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	cpu6502_instr_if.sink            instr,
	cpu6502_retire_if.source         retire
);
	import cpu6502_pkg::*;

	logic         valid_s1;
	instr_item_t  item_s1;
	logic         out_valid_q;
	retire_item_t out_q;

	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [7:0] a_n, x_n, y_n, sp_n;
	logic       n_f, v_f, d_f, i_f, z_f, c_f;
	logic [7:0] res, src, sh, nz_val, m, m_add, cmp_reg;
	logic       wb, br, nz_en, is_shift, add_en, cmp_en;
	logic [8:0] sum, diff;
	logic       advance;

	// Handshake
	assign advance     = valid_s1 && (!out_valid_q || retire.ready);
	assign instr.ready = !valid_s1 || advance;
	assign retire.valid = out_valid_q;
	assign retire.data  = out_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			item_s1 <= instr.data;
		end
	end

	// Shared adder and comparator
	assign m     = item_s1.operand;
	assign m_add = (item_s1.kind == OP_SBC) ? ~m : m;
	assign sum   = {1'b0, a_q} + {1'b0, m_add} + {8'd0, p_q[0]};
	assign diff  = {1'b0, cmp_reg} - {1'b0, m};
	assign src   = item_s1.on_accumulator ? a_q : m;

	// Execute
	always_comb begin
		a_n = a_q;
		x_n = x_q;
		y_n = y_q;
		sp_n = sp_q;
		n_f = p_q[7];
		v_f = p_q[6];
		d_f = p_q[3];
		i_f = p_q[2];
		z_f = p_q[1];
		c_f = p_q[0];
		res = 8'd0;
		wb = 1'b0;
		br = 1'b0;
		nz_en = 1'b0;
		nz_val = 8'd0;
		is_shift = 1'b0;
		sh = 8'd0;
		add_en = 1'b0;
		cmp_en = 1'b0;
		cmp_reg = a_q;

		unique case (item_s1.kind)
			OP_ADC, OP_SBC: add_en = 1'b1;
			OP_AND: begin
				a_n = a_q & m;
				nz_en = 1'b1; nz_val = a_n;
			end
			OP_ASL: begin
				c_f = src[7]; sh = {src[6:0], 1'b0}; is_shift = 1'b1;
			end
			OP_BCC: br = !p_q[0];
			OP_BCS: br = p_q[0];
			OP_BEQ: br = p_q[1];
			OP_BMI: br = p_q[7];
			OP_BNE: br = !p_q[1];
			OP_BPL: br = !p_q[7];
			OP_BVC: br = !p_q[6];
			OP_BVS: br = p_q[6];
			OP_BIT: begin
				n_f = m[7]; v_f = m[6]; z_f = ((a_q & m) == 8'd0);
			end
			OP_BRK: begin
				res = {p_q[7:6], 2'b11, p_q[3:0]}; wb = 1'b1;
				sp_n = sp_q - 8'd3; i_f = 1'b1;
			end
			OP_CLC: c_f = 1'b0;
			OP_CLD: d_f = 1'b0;
			OP_CLI: i_f = 1'b0;
			OP_CLV: v_f = 1'b0;
			OP_CMP: cmp_en = 1'b1;
			OP_CPX: begin
				cmp_en = 1'b1; cmp_reg = x_q;
			end
			OP_CPY: begin
				cmp_en = 1'b1; cmp_reg = y_q;
			end
			OP_DEC: begin
				res = m - 8'd1; wb = 1'b1; nz_en = 1'b1; nz_val = res;
			end
			OP_DEX: begin
				x_n = x_q - 8'd1; nz_en = 1'b1; nz_val = x_n;
			end
			OP_DEY: begin
				y_n = y_q - 8'd1; nz_en = 1'b1; nz_val = y_n;
			end
			OP_EOR: begin
				a_n = a_q ^ m; nz_en = 1'b1; nz_val = a_n;
			end
			OP_INC: begin
				res = m + 8'd1; wb = 1'b1; nz_en = 1'b1; nz_val = res;
			end
			OP_INX: begin
				x_n = x_q + 8'd1; nz_en = 1'b1; nz_val = x_n;
			end
			OP_INY: begin
				y_n = y_q + 8'd1; nz_en = 1'b1; nz_val = y_n;
			end
			OP_JSR: sp_n = sp_q - 8'd2;
			OP_LDA: begin
				a_n = m; nz_en = 1'b1; nz_val = m;
			end
			OP_LDX: begin
				x_n = m; nz_en = 1'b1; nz_val = m;
			end
			OP_LDY: begin
				y_n = m; nz_en = 1'b1; nz_val = m;
			end
			OP_LSR: begin
				c_f = src[0]; sh = {1'b0, src[7:1]}; is_shift = 1'b1;
			end
			OP_ORA: begin
				a_n = a_q | m; nz_en = 1'b1; nz_val = a_n;
			end
			OP_PHA: begin
				res = a_q; wb = 1'b1; sp_n = sp_q - 8'd1;
			end
			OP_PHP: begin
				res = {p_q[7:6], 2'b11, p_q[3:0]}; wb = 1'b1;
				sp_n = sp_q - 8'd1;
			end
			OP_PLA: begin
				sp_n = sp_q + 8'd1; a_n = m; nz_en = 1'b1; nz_val = m;
			end
			OP_PLP, OP_RTI: begin
				sp_n = (item_s1.kind == OP_RTI) ? sp_q + 8'd3 : sp_q + 8'd1;
				n_f = m[7]; v_f = m[6]; d_f = m[3];
				i_f = m[2]; z_f = m[1]; c_f = m[0];
			end
			OP_ROL: begin
				c_f = src[7]; sh = {src[6:0], p_q[0]}; is_shift = 1'b1;
			end
			OP_ROR: begin
				c_f = src[0]; sh = {p_q[0], src[7:1]}; is_shift = 1'b1;
			end
			OP_RTS: sp_n = sp_q + 8'd2;
			OP_SEC: c_f = 1'b1;
			OP_SED: d_f = 1'b1;
			OP_SEI: i_f = 1'b1;
			OP_STA: begin
				res = a_q; wb = 1'b1;
			end
			OP_STX: begin
				res = x_q; wb = 1'b1;
			end
			OP_STY: begin
				res = y_q; wb = 1'b1;
			end
			OP_TAX: begin
				x_n = a_q; nz_en = 1'b1; nz_val = a_q;
			end
			OP_TAY: begin
				y_n = a_q; nz_en = 1'b1; nz_val = a_q;
			end
			OP_TSX: begin
				x_n = sp_q; nz_en = 1'b1; nz_val = sp_q;
			end
			OP_TXA: begin
				a_n = x_q; nz_en = 1'b1; nz_val = x_q;
			end
			OP_TXS: sp_n = x_q;
			OP_TYA: begin
				a_n = y_q; nz_en = 1'b1; nz_val = y_q;
			end
			default: ;
		endcase

		// Binary add with carry in; SBC feeds the inverted operand
		if (add_en) begin
			a_n = sum[7:0];
			v_f = (~(a_q[7] ^ m_add[7])) & (a_q[7] ^ sum[7]);
			c_f = sum[8];
			nz_en = 1'b1; nz_val = sum[7:0];
		end

		// Compare: carry set when register >= operand
		if (cmp_en) begin
			c_f = !diff[8];
			nz_en = 1'b1; nz_val = diff[7:0];
		end

		// Shift result goes to A or back to memory
		if (is_shift) begin
			nz_en = 1'b1; nz_val = sh;
			if (item_s1.on_accumulator) begin
				a_n = sh;
			end else begin
				res = sh; wb = 1'b1;
			end
		end

		if (nz_en) begin
			n_f = nz_val[7];
			z_f = (nz_val == 8'd0);
		end
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'd0;
			x_q <= 8'd0;
			y_q <= 8'd0;
			sp_q <= SP_RESET;
			p_q <= 8'd0;
		end else if (advance) begin
			a_q <= a_n;
			x_q <= x_n;
			y_q <= y_n;
			sp_q <= sp_n;
			p_q <= {n_f, v_f, 2'b00, d_f, i_f, z_f, c_f};
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (retire.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.result_byte <= res;
			out_q.write_back <= wb;
			out_q.branch_taken <= br;
			out_q.acc_value <= a_n;
			out_q.index_x_value <= x_n;
			out_q.index_y_value <= y_n;
			out_q.stack_value <= sp_n;
			out_q.status_value <= {n_f, v_f, 2'b00, d_f, i_f, z_f, c_f};
		end
	end

	// Checks
	ap_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[5:4] == 2'b00)
		else $error("status bits 5:4 set");

	ap_status_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status_value == p_q)
		else $error("retired status differs from P");

	ap_retire_next: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("executed item not presented");

	ap_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.write_back) |-> out_q.result_byte == 8'd0)
		else $error("result byte without write-back");

endmodule

`default_nettype wire
